FILE: design/led_fade_gamma_dimmer_assert.svh
// assertion helpers for the led fade engine
`ifndef LED_FADE_GAMMA_DIMMER_ASSERT_SVH
`define LED_FADE_GAMMA_DIMMER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LFG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LFG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lfg_pkg.sv
// ----------------------------------------------------------------------------
// lfg_pkg
// Shared types and constants of the led fade engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lfg_pkg;

    // configuration port
    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 22;

    localparam logic [REG_IDX_W-1:0] REG_LIMIT0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FAST   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SLOW   = 3'd5;

    localparam logic [9:0]  LIMIT_RESET = 10'd921;
    localparam logic [21:0] FAST_RESET  = 22'd214539;
    localparam logic [21:0] SLOW_RESET  = 22'd4768;

    // opcodes and speeds
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] SPEED_IMM  = 2'd0;
    localparam logic [1:0] SPEED_FAST = 2'd1;

    // duty format and ramp
    localparam int          FRAC_BITS = 22;
    localparam logic [31:0] SNAP_DIST = 32'd3774874;
    localparam logic [6:0]  PCT_MAX   = 7'd100;

    // divide by 100 as multiply by ceil(2^24/100), exact below 2^17
    localparam logic [21:0] PCT_RECIP    = 22'd167773;
    localparam int          PCT_RECIP_SH = 24;

    // shared divider
    localparam int DVD_W = 26;
    localparam int DVS_W = 10;

    // shared multiplier
    localparam int MUL_A_W = 22;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

FILE: design/lfg_cmd_if.sv
// ----------------------------------------------------------------------------
// lfg_cmd_if
// Command channel: set and tick words with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfg_cmd_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [1:0]  channel;
    logic [6:0]  percent;
    logic [1:0]  speed;
    logic [15:0] elapsed_ms;

    modport source (output valid, opcode, channel, percent, speed, elapsed_ms,
                    input ready);
    modport sink   (input valid, opcode, channel, percent, speed, elapsed_ms,
                    output ready);
endinterface

`default_nettype wire

FILE: design/lfg_lvl_if.sv
// ----------------------------------------------------------------------------
// lfg_lvl_if
// Level channel: one drive level word per updated channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfg_lvl_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_channel;
    logic [9:0] drive_level;
    logic [9:0] linear_duty;
    logic       arrived;
    logic       last;

    modport source (output valid, out_channel, drive_level, linear_duty, arrived, last,
                    input ready);
    modport sink   (input valid, out_channel, drive_level, linear_duty, arrived, last,
                    output ready);
endinterface

`default_nettype wire

FILE: design/lfg_div.sv
// ----------------------------------------------------------------------------
// lfg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfg_div (
    input  logic             clk,
    input  logic             rst_n,
    input  lfg_pkg::div_req_t req,
    output logic             busy,
    output logic             done,
    output logic [lfg_pkg::DVD_W-1:0] quotient
);
    import lfg_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in from the bottom
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : DVS_W'(rem_sh);
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

FILE: design/lfg_rom.sv
// ----------------------------------------------------------------------------
// lfg_rom
// Gamma 2.5 table in Q1.16, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lfg_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                         clk,
    input  logic [$clog2(DEPTH+1)-1:0]   addr,
    output logic [16:0]                  data
);
    typedef logic [16:0] rom_arr_t [0:DEPTH];

    function automatic logic [16:0] gamma_entry(input int unsigned i);
        logic [63:0] x30;
        logic [63:0] x2;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] p;
        x30 = (64'(i) << 30) / 64'(DEPTH);
        x2  = (x30 * x30) >> 30;
        // integer square root of x30 << 30
        v = x30 << 30;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        p = (x2 * r) >> 30;
        return 17'((p + 64'd8192) >> 14);
    endfunction

    function automatic rom_arr_t build_rom();
        rom_arr_t t;
        for (int i = 0; i <= DEPTH; i++)
            t[i] = gamma_entry(i);
        return t;
    endfunction

    localparam rom_arr_t ROM = build_rom();

    logic [16:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: design/led_fade_gamma_dimmer.sv
// set word: two passes through the shared multiplier (the second a
//   reciprocal multiply for the divide by 100); an immediate set then runs the
//   gamma path before its level word, cut short when the level is 0 or the limit
// tick word: idle channels are skipped; each moving channel takes a step, rounding and
//   the gamma path (cut short when the level is 0 or the limit), plus any output stall
// reset: channel state zero, limits 921, rates at default; no clearing pass
// ----------------------------------------------------------------------------
// led_fade_gamma_dimmer
// Four-channel fade engine with gamma 2.5 levels, one shared multiplier and
// divider under a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_fade_gamma_dimmer_assert.svh"

module led_fade_gamma_dimmer #(
    parameter int CHANNEL_COUNT     = 4,
    parameter int FULL_SCALE        = 1023,
    parameter int GAMMA_TABLE_DEPTH = 1024
) (
    input  logic clk,
    input  logic rst_n,
    lfg_cmd_if.sink   cmd,
    lfg_lvl_if.source lvl,
    input  logic                             wr_en,
    input  logic [lfg_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [lfg_pkg::REG_DATA_W-1:0]   wr_data
);
    import lfg_pkg::*;

    localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int IDX_W = $clog2(GAMMA_TABLE_DEPTH + 1);
    localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(CHANNEL_COUNT - 1);
    localparam logic [15:0]      FULL_LVL = 16'(FULL_SCALE);
    localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(GAMMA_TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(GAMMA_TABLE_DEPTH - 1);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SET_MUL   = 5'd1;
    localparam logic [4:0] S_SET_DIV   = 5'd2;
    localparam logic [4:0] S_SET_WAIT  = 5'd3;
    localparam logic [4:0] S_SET_UPD   = 5'd4;
    localparam logic [4:0] S_TICK_SCAN = 5'd5;
    localparam logic [4:0] S_TICK_MUL  = 5'd6;
    localparam logic [4:0] S_TICK_UPD  = 5'd7;
    localparam logic [4:0] S_TICK_RND  = 5'd8;
    localparam logic [4:0] S_G_START   = 5'd9;
    localparam logic [4:0] S_G_DIVW    = 5'd10;
    localparam logic [4:0] S_G_POS     = 5'd11;
    localparam logic [4:0] S_G_RD0     = 5'd12;
    localparam logic [4:0] S_G_RD1     = 5'd13;
    localparam logic [4:0] S_G_DIFF    = 5'd14;
    localparam logic [4:0] S_G_INTERP  = 5'd15;
    localparam logic [4:0] S_G_SUM     = 5'd16;
    localparam logic [4:0] S_G_SCALE   = 5'd17;
    localparam logic [4:0] S_G_LEVEL   = 5'd18;
    localparam logic [4:0] S_EMIT      = 5'd19;

    // configuration
    logic [9:0]  limit_reg [4];
    logic [21:0] fast_reg;
    logic [21:0] slow_reg;

    // per-channel state
    logic [31:0]              cur_reg [CHANNEL_COUNT];
    logic [9:0]               tgt_reg [CHANNEL_COUNT];
    logic [1:0]               spd_reg [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] moving_reg;

    // sequencer
    logic [4:0]      state_reg;
    logic [4:0]      state_next;
    logic [CH_W-1:0] ptr_reg;
    logic [6:0]      pct_reg;
    logic [1:0]      spd_in_reg;
    logic [15:0]     el_reg;
    logic [9:0]      tgt_new_reg;

    // gamma datapath
    logic [10:0]      raw_reg;
    logic             arr_reg;
    logic             last_reg;
    logic [15:0]      q_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]      frac_reg;
    logic [16:0]      t0_reg;
    logic [16:0]      diff_reg;
    logic [16:0]      g_reg;
    logic [15:0]      level_reg;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_reg;

    // output word
    logic       lvl_valid_reg;
    logic [1:0] o_chan_reg;
    logic [9:0] o_drive_reg;
    logic [9:0] o_lin_reg;
    logic       o_arr_reg;
    logic       o_last_reg;

    // shared divider
    div_req_t         div_req;
    logic             div_busy;
    logic             div_done;
    logic [DVD_W-1:0] div_q;

    logic [16:0]      rom_data;
    logic [IDX_W-1:0] rom_addr;

    logic [9:0]       lim_sel;
    logic [21:0]      rate_sel;
    logic [31:0]      cur_sel;
    logic [31:0]      tq;
    logic [31:0]      step;
    logic [31:0]      gap;
    logic             snap;
    logic [10:0]      rnd_cur;
    logic             last_calc;
    logic             g_zero;
    logic             g_sat;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] idx_clamp;
    logic [10:0]      lvl_scaled;
    logic             emit_fire;
    logic [6:0]       pct_clamp;

    function automatic logic [10:0] rounded(input logic [31:0] d);
        logic [32:0] s;
        s = {1'b0, d} + (33'd1 << (FRAC_BITS - 1));
        return s[32:FRAC_BITS];
    endfunction

    function automatic logic [15:0] clamp_full(input logic [10:0] x);
        return (16'(x) > FULL_LVL) ? FULL_LVL : 16'(x);
    endfunction

    lfg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    lfg_rom #(.DEPTH(GAMMA_TABLE_DEPTH)) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign lim_sel   = limit_reg[2'(32'(ptr_reg))];
    assign rate_sel  = (spd_reg[ptr_reg] == SPEED_FAST) ? fast_reg : slow_reg;
    assign cur_sel   = cur_reg[ptr_reg];
    assign tq        = {tgt_reg[ptr_reg], {FRAC_BITS{1'b0}}};
    assign step      = (|prod_reg[PROD_W-1:32]) ? 32'hFFFF_FFFF : prod_reg[31:0];
    assign gap       = (cur_sel < tq) ? tq - cur_sel : cur_sel - tq;
    assign snap      = (step >= gap) || (gap < SNAP_DIST);
    assign rnd_cur   = rounded(cur_sel);
    assign g_zero    = (raw_reg == '0) || (lim_sel == '0);
    assign g_sat     = raw_reg >= {1'b0, lim_sel};
    assign pos_idx   = prod_reg[16 +: IDX_W];
    assign idx_clamp = (pos_idx >= IDX_TOP) ? IDX_MAX : pos_idx;
    assign rom_addr  = (state_reg == S_G_RD0) ? idx_clamp : idx_reg + 1'b1;
    assign lvl_scaled = (prod_reg[26:16] > {1'b0, lim_sel}) ? {1'b0, lim_sel}
                                                            : prod_reg[26:16];
    assign emit_fire = (state_reg == S_EMIT) && (!lvl_valid_reg || lvl.ready);
    assign pct_clamp = (cmd.percent > PCT_MAX) ? PCT_MAX : cmd.percent;

    // no moving channel above the pointer means this word closes the tick
    always_comb
    begin
        last_calc = 1'b1;
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            if ((i > 32'(ptr_reg)) && moving_reg[i])
                last_calc = 1'b0;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_SET_MUL:  begin mul_a = MUL_A_W'(pct_reg); mul_b = MUL_B_W'(lim_sel); end
            S_SET_DIV:  begin mul_a = PCT_RECIP;         mul_b = prod_reg[16:0];    end
            S_TICK_MUL: begin mul_a = rate_sel;          mul_b = MUL_B_W'(el_reg);  end
            S_G_POS:    begin mul_a = MUL_A_W'(q_reg);
                              mul_b = MUL_B_W'(GAMMA_TABLE_DEPTH); end
            S_G_INTERP: begin mul_a = MUL_A_W'(diff_reg); mul_b = MUL_B_W'(frac_reg); end
            S_G_SCALE:  begin mul_a = MUL_A_W'(g_reg);    mul_b = MUL_B_W'(lim_sel);  end
            default:    begin mul_a = '0;                 mul_b = '0;                 end
        endcase
    end

    always_comb
    begin
        div_req.start    = (state_reg == S_G_START) && !g_zero && !g_sat;
        div_req.dividend = {raw_reg[9:0], 16'b0};
        div_req.divisor  = lim_sel;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.opcode == OP_SET)
                    begin
                        if (32'(cmd.channel) < CHANNEL_COUNT)
                            state_next = S_SET_MUL;
                    end
                    else if (cmd.elapsed_ms != '0)
                        state_next = S_TICK_SCAN;
                end
            end
            S_SET_MUL:  state_next = S_SET_DIV;
            S_SET_DIV:  state_next = S_SET_WAIT;
            S_SET_WAIT: state_next = S_SET_UPD;
            S_SET_UPD:  state_next = (spd_in_reg == SPEED_IMM) ? S_G_START : S_IDLE;
            S_TICK_SCAN:
            begin
                if (moving_reg[ptr_reg])
                    state_next = S_TICK_MUL;
                else if (ptr_reg == LAST_CH)
                    state_next = S_IDLE;
            end
            S_TICK_MUL: state_next = S_TICK_UPD;
            S_TICK_UPD: state_next = S_TICK_RND;
            S_TICK_RND: state_next = S_G_START;
            S_G_START:  state_next = (g_zero || g_sat) ? S_EMIT : S_G_DIVW;
            S_G_DIVW:   state_next = div_done ? S_G_POS : S_G_DIVW;
            S_G_POS:    state_next = S_G_RD0;
            S_G_RD0:    state_next = S_G_RD1;
            S_G_RD1:    state_next = S_G_DIFF;
            S_G_DIFF:   state_next = S_G_INTERP;
            S_G_INTERP: state_next = S_G_SUM;
            S_G_SUM:    state_next = S_G_SCALE;
            S_G_SCALE:  state_next = S_G_LEVEL;
            S_G_LEVEL:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_fire)
                    state_next = last_reg ? S_IDLE : S_TICK_SCAN;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            lvl_valid_reg <= 1'b0;
            moving_reg    <= '0;
            fast_reg      <= FAST_RESET;
            slow_reg      <= SLOW_RESET;
            for (int i = 0; i < 4; i++)
                limit_reg[i] <= LIMIT_RESET;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
                spd_reg[i] <= SPEED_IMM;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (wr_en)
            begin
                case (wr_index)
                    REG_LIMIT0: limit_reg[0] <= wr_data[9:0];
                    REG_LIMIT1: limit_reg[1] <= wr_data[9:0];
                    REG_LIMIT2: limit_reg[2] <= wr_data[9:0];
                    REG_LIMIT3: limit_reg[3] <= wr_data[9:0];
                    REG_FAST:   fast_reg     <= wr_data;
                    REG_SLOW:   slow_reg     <= wr_data;
                    default:    ;
                endcase
            end

            if (lvl.ready)
                lvl_valid_reg <= 1'b0;
            if (emit_fire)
                lvl_valid_reg <= 1'b1;

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                        ptr_reg <= (cmd.opcode == OP_SET) ? CH_W'(32'(cmd.channel)) : '0;
                end
                S_TICK_SCAN:
                begin
                    if (!moving_reg[ptr_reg] && (ptr_reg != LAST_CH))
                        ptr_reg <= ptr_reg + 1'b1;
                end
                S_SET_UPD:
                begin
                    moving_reg[ptr_reg] <= 1'b0;
                    tgt_reg[ptr_reg]    <= tgt_new_reg;
                    spd_reg[ptr_reg]    <= spd_in_reg;
                    if (spd_in_reg == SPEED_IMM)
                        cur_reg[ptr_reg] <= {tgt_new_reg, {FRAC_BITS{1'b0}}};
                    else if (rnd_cur != {1'b0, tgt_new_reg})
                        moving_reg[ptr_reg] <= 1'b1;
                    else
                        cur_reg[ptr_reg] <= {tgt_new_reg, {FRAC_BITS{1'b0}}};
                end
                S_TICK_UPD:
                begin
                    if (snap)
                    begin
                        cur_reg[ptr_reg]    <= tq;
                        moving_reg[ptr_reg] <= 1'b0;
                    end
                    else if (cur_sel < tq)
                        cur_reg[ptr_reg] <= cur_sel + step;
                    else
                        cur_reg[ptr_reg] <= cur_sel - step;
                end
                S_EMIT:
                begin
                    if (emit_fire && !last_reg)
                        ptr_reg <= ptr_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if ((state_reg == S_IDLE) && cmd.valid)
        begin
            pct_reg    <= pct_clamp;
            spd_in_reg <= cmd.speed;
            el_reg     <= cmd.elapsed_ms;
        end

        case (state_reg)
            S_SET_WAIT: tgt_new_reg <= prod_reg[PCT_RECIP_SH +: 10];
            S_SET_UPD:
            begin
                raw_reg  <= {1'b0, tgt_new_reg};
                arr_reg  <= 1'b1;
                last_reg <= 1'b1;
            end
            S_TICK_RND:
            begin
                raw_reg  <= rnd_cur;
                arr_reg  <= !moving_reg[ptr_reg];
                last_reg <= last_calc;
            end
            S_G_START:  level_reg <= g_zero ? 16'd0 : clamp_full({1'b0, lim_sel});
            S_G_DIVW:   q_reg     <= div_q[15:0];
            S_G_RD0:
            begin
                idx_reg  <= idx_clamp;
                frac_reg <= prod_reg[15:0];
            end
            S_G_RD1:    t0_reg   <= rom_data;
            S_G_DIFF:   diff_reg <= (rom_data >= t0_reg) ? rom_data - t0_reg : 17'd0;
            S_G_SUM:    g_reg    <= t0_reg + prod_reg[32:16];
            S_G_LEVEL:  level_reg <= clamp_full(lvl_scaled);
            default: ;
        endcase

        if (emit_fire)
        begin
            o_chan_reg  <= 2'(32'(ptr_reg));
            o_drive_reg <= 10'(FULL_LVL - level_reg);
            o_lin_reg   <= raw_reg[9:0];
            o_arr_reg   <= arr_reg;
            o_last_reg  <= last_reg;
        end
    end

    assign cmd.ready       = (state_reg == S_IDLE);
    assign lvl.valid       = lvl_valid_reg;
    assign lvl.out_channel = o_chan_reg;
    assign lvl.drive_level = o_drive_reg;
    assign lvl.linear_duty = o_lin_reg;
    assign lvl.arrived     = o_arr_reg;
    assign lvl.last        = o_last_reg;

    `LFG_ASSERT_NOW(a_arrived_tracks_moving, emit_fire, arr_reg == !moving_reg[ptr_reg], "arrived flag disagrees with channel moving state")
    `LFG_ASSERT_NEXT(a_last_word_ends_item, emit_fire && last_reg, state_reg == S_IDLE, "sequencer did not return to idle after last word")
    `LFG_ASSERT_NOW(a_divider_free_when_idle, cmd.ready, !div_busy, "divider busy while command channel is ready")

endmodule

`default_nettype wire
